@@ rtl/core/feedback_echo_delay_unit_macros.svh @@
// ----------------------------------------------------------------------------
// feedback echo delay unit assertion macros
// concurrent assertion shorthands for the echo delay rtl
// ----------------------------------------------------------------------------
`ifndef FEEDBACK_ECHO_DELAY_UNIT_MACROS_SVH
`define FEEDBACK_ECHO_DELAY_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define FED_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("fed assertion failed");

// next-cycle implication, disabled while reset is low
`define FED_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("fed assertion failed");

`endif

@@ rtl/core/fed_pkg.sv @@
// ----------------------------------------------------------------------------
// fed_pkg
// types and constants of the feedback echo delay unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fed_pkg;

  localparam int IN_WIDTH    = 16;
  localparam int OUT_WIDTH   = 16;
  localparam int DELAY_WIDTH = 17;
  localparam int GAIN_WIDTH  = 16;
  localparam int GAIN_FRAC   = 15;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam logic [DELAY_WIDTH-1:0] DELAY_LENGTH_RESET = 17'd24000;
  localparam logic [GAIN_WIDTH-1:0]  MIX_GAIN_RESET     = 16'd16384;
  localparam logic [GAIN_WIDTH-1:0]  GAIN_UNITY         = 16'd32768;

  // register index, taken from the word address bit of paddr
  typedef enum logic [0:0] {
    REG_DELAY_LENGTH = 1'b0,
    REG_MIX_GAIN     = 1'b1
  } reg_index_e;

endpackage

`default_nettype wire

@@ rtl/core/feedback_echo_delay_unit.sv @@
// ----------------------------------------------------------------------------
// feedback_echo_delay_unit
// feedback echo on a stream of signed audio samples around a circular delay ram
// ----------------------------------------------------------------------------
// Usage:
//   Input samples arrive on in_valid_i / in_ready_o / sample_in_i, results
//   leave on out_valid_o / out_ready_i / sample_out_o, one result for every
//   input transaction, in order.
//   Each sample reads the entry delay_length positions behind the write
//   pointer, stores input plus half the delayed sample (saturated) and
//   outputs input plus delayed times mix_gain (Q1.15, rounded, saturated).
//   An input transaction passes stage 1, stage 2 and the result register
//   before out_valid_o rises. One sample is taken every cycle while
//   in_ready_o is high: the delay ram does one read and one write per
//   sample on separate ports, and a write still pending from the previous
//   sample is forwarded to the read that hits it.
//   The user must write delay_length and mix_gain over the APB port only
//   while the block is idle (not enforced by the block); delay 0 acts as 1,
//   longer delays clamp to STORE_DEPTH-1 and gains above 1.0 clamp to 1.0.
//   Reset clears the pointer and the pipeline at once; ram entries not yet
//   written since reset read as zero through a fill mark, so no clear pass
//   is needed and samples are taken from the first cycle after reset.
//   When the receiver stalls, the three stages fill up and in_ready_o falls
//   only once the result register and both stages ahead of it are occupied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "feedback_echo_delay_unit_macros.svh"

module feedback_echo_delay_unit #(
  parameter int STORE_DEPTH = 131072,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [fed_pkg::IN_WIDTH-1:0] sample_in_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [fed_pkg::OUT_WIDTH-1:0]     sample_out_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [fed_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [fed_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [fed_pkg::APB_DATA_W-1:0]           prdata,
  output logic                                     pready
);

  import fed_pkg::*;

  localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int DW  = (AW > DELAY_WIDTH) ? AW : DELAY_WIDTH;
  localparam int SB  = SAMPLE_BITS;
  localparam int FBW = ((IN_WIDTH > SB) ? IN_WIDTH : SB) + 1;
  localparam int PW  = SB + GAIN_WIDTH + 1;
  localparam int MW  = PW - GAIN_FRAC;
  localparam int YW  = ((IN_WIDTH > MW) ? IN_WIDTH : MW) + 1;

  localparam logic [AW-1:0] DEPTH_A    = AW'(STORE_DEPTH);
  localparam logic [AW-1:0] LAST_PTR   = AW'(STORE_DEPTH - 1);
  localparam logic [DW-1:0] MAX_DELAY  = DW'(STORE_DEPTH - 1);
  localparam logic [PW-1:0] ROUND_HALF = PW'(1) << (GAIN_FRAC - 1);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [DELAY_WIDTH-1:0] delay_q;
  logic [GAIN_WIDTH-1:0]  gain_q;
  logic                   cfg_wr;
  reg_index_e             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_index_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_LENGTH_RESET;
      gain_q  <= MIX_GAIN_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DELAY_LENGTH: delay_q <= pwdata[DELAY_WIDTH-1:0];
        REG_MIX_GAIN:     gain_q  <= pwdata[GAIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DELAY_LENGTH: prdata = APB_DATA_W'(delay_q);
      REG_MIX_GAIN:     prdata = APB_DATA_W'(gain_q);
      default:          prdata = '0;
    endcase
  end

  // clamped settings
  logic [DW-1:0]         delay_ext;
  logic [DW-1:0]         delay_clamp;
  logic [AW-1:0]         delay_a;
  logic [GAIN_WIDTH-1:0] gain_clamp;

  always_comb begin
    delay_ext = DW'(delay_q);
    if (delay_ext == '0) begin
      delay_clamp = DW'(1);
    end else if (delay_ext > MAX_DELAY) begin
      delay_clamp = MAX_DELAY;
    end else begin
      delay_clamp = delay_ext;
    end
    delay_a    = delay_clamp[AW-1:0];
    gain_clamp = (gain_q > GAIN_UNITY) ? GAIN_UNITY : gain_q;
  end

  // --------------------------------------------------------------------------
  // pipeline control
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic en1, en2, en3;
  logic accept;

  assign en3        = !out_valid_q || out_ready_i;
  assign en2        = !s2_valid_q || en3;
  assign en1        = !s1_valid_q || en2;
  assign in_ready_o = en1;
  assign accept     = in_valid_i && en1;

  // --------------------------------------------------------------------------
  // write pointer, fill mark and read address
  // --------------------------------------------------------------------------
  logic [AW-1:0] wp_q, wp_d;
  logic          wrapped_q;
  logic [AW:0]   rp_diff;
  logic [AW-1:0] rp;
  logic          rd_valid;

  always_comb begin
    wp_d    = (wp_q == LAST_PTR) ? '0 : wp_q + 1'b1;
    rp_diff = {1'b0, wp_q} - {1'b0, delay_a};
    rp      = rp_diff[AW] ? (rp_diff[AW-1:0] + DEPTH_A) : rp_diff[AW-1:0];
    // entries ahead of the pointer are untouched until the first wrap
    rd_valid = wrapped_q || (rp < wp_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
    end else if (accept) begin
      wp_q <= wp_d;
      if (wp_q == LAST_PTR) begin
        wrapped_q <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // delay ram
  // --------------------------------------------------------------------------
  logic [SB-1:0] mem [STORE_DEPTH];
  logic [SB-1:0] rdata_q;
  logic          mem_we;
  logic [SB-1:0] mem_wdata;
  logic [AW-1:0] s1_ptr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[s1_ptr_q] <= mem_wdata;
    end
    if (accept) begin
      rdata_q <= mem[rp];
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: delayed sample, feedback write, echo product
  // --------------------------------------------------------------------------
  logic signed [IN_WIDTH-1:0] s1_x_q;
  logic                       s1_rd_valid_q;
  logic                       s1_fwd_q;
  logic signed [SB-1:0]       s1_fwd_data_q;

  logic signed [SB-1:0]  delayed;
  logic signed [SB-1:0]  delayed_half;
  logic signed [FBW-1:0] fb_sum;
  logic [FBW-SB:0]       fb_top;
  logic signed [SB-1:0]  fb_sat;
  logic signed [PW-1:0]  prod;
  logic                  fwd_hit;

  always_comb begin
    if (s1_fwd_q) begin
      delayed = s1_fwd_data_q;
    end else if (s1_rd_valid_q) begin
      delayed = $signed(rdata_q);
    end else begin
      delayed = '0;
    end
    delayed_half = delayed >>> 1;
    fb_sum       = FBW'(s1_x_q) + FBW'(delayed_half);
    fb_top       = fb_sum[FBW-1:SB-1];
    if ((&fb_top) || !(|fb_top)) begin
      fb_sat = fb_sum[SB-1:0];
    end else begin
      fb_sat = fb_sum[FBW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    end
    prod = PW'(delayed) * PW'($signed({1'b0, gain_clamp}));
  end

  assign mem_we    = s1_valid_q && en2;
  assign mem_wdata = fb_sat;
  // the entry still held in stage 1 lands in the ram at the same edge as the read
  assign fwd_hit   = s1_valid_q && (s1_ptr_q == rp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en1) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q        <= sample_in_i;
      s1_ptr_q      <= wp_q;
      s1_rd_valid_q <= rd_valid;
      s1_fwd_q      <= fwd_hit;
      s1_fwd_data_q <= fb_sat;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: rounding and output mix
  // --------------------------------------------------------------------------
  logic signed [IN_WIDTH-1:0] s2_x_q;
  logic signed [PW-1:0]       s2_prod_q;

  logic signed [PW-1:0]  prod_rnd;
  logic signed [MW-1:0]  mixed;
  logic signed [YW-1:0]  y_sum;
  logic [YW-SB:0]        y_top;
  logic signed [SB-1:0]  y_sat;

  always_comb begin
    prod_rnd = s2_prod_q + $signed(ROUND_HALF);
    mixed    = prod_rnd[PW-1:GAIN_FRAC];
    y_sum    = YW'(s2_x_q) + YW'(mixed);
    y_top    = y_sum[YW-1:SB-1];
    if ((&y_top) || !(|y_top)) begin
      y_sat = y_sum[SB-1:0];
    end else begin
      y_sat = y_sum[YW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (en3) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  logic signed [OUT_WIDTH-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (en2 && s1_valid_q) begin
      s2_x_q    <= s1_x_q;
      s2_prod_q <= prod;
    end
    if (en3 && s2_valid_q) begin
      out_q <= OUT_WIDTH'(y_sat);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  logic [AW-1:0] s1_ptr_succ;

  assign s1_ptr_succ = (s1_ptr_q == LAST_PTR) ? '0 : s1_ptr_q + 1'b1;

  // stage 1 always holds the most recently taken sample
  `FED_ASSERT_IMPL(a_s1_is_last, clk_i, rst_ni, s1_valid_q, s1_ptr_succ == wp_q)
  // a forwarded entry was always written since reset
  `FED_ASSERT_IMPL(a_fwd_has_src, clk_i, rst_ni, s1_valid_q && s1_fwd_q, s1_rd_valid_q)
  `FED_ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !en2,
                   s1_valid_q && $stable(s1_x_q) && $stable(s1_ptr_q))
  `FED_ASSERT_IMPL(a_no_write_idle, clk_i, rst_ni, mem_we, s1_valid_q && en2)

endmodule

`default_nettype wire
